// ----- hdl/wav_stereo_stream_deframer_assert.svh -----
// Assertion macros used by the deframer parser front end (wssd_front).
// Each macro names a clock and a synchronous reset and checks one implication.
`ifndef WAV_STEREO_STREAM_DEFRAMER_ASSERT_SVH
`define WAV_STEREO_STREAM_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSSD_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wssd: same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define WSSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wssd: next-cycle implication failed");

`endif

// ----- hdl/wssd_pkg.sv -----
// Shared types and constants for the WAV stereo stream deframer.
// No dependencies; the parser, queue, output stage and top level use this package.
`default_nettype none

package wssd_pkg;

   // Default number of entries in the queue between the parser and the output stage.
   localparam int unsigned WSSD_QUEUE_DEPTH = 2;

   // Little-endian chunk tags and the required format fields.
   localparam logic [31:0] TAG_RIFF        = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE        = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT         = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA        = 32'h6174_6164;
   localparam logic [31:0] PCM_FORMAT_TAG  = 32'h0000_0001;
   localparam logic [31:0] STEREO_CHANNELS = 32'h0000_0002;

   typedef enum logic [1:0] {
      ST_PAIR   = 2'd0,
      ST_FORMAT = 2'd1,
      ST_DONE   = 2'd2,
      ST_ERROR  = 2'd3
   } wssd_status_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_RIFF      = 3'd1,
      ERR_WAVE      = 3'd2,
      ERR_FMT       = 3'd3,
      ERR_TAG       = 3'd4,
      ERR_CHANNELS  = 3'd5,
      ERR_DATA_TAG  = 3'd6,
      ERR_TRUNCATED = 3'd7
   } wssd_error_kind_type;

   // One queued result: everything except the header values.
   typedef struct packed {
      wssd_status_type     status;
      wssd_error_kind_type kind;
      logic [15:0]         left;
      logic [15:0]         right;
   } wssd_entry_type;

   // Header values held by the parser and shown in every result.
   typedef struct packed {
      logic [31:0] rate_hz;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] sample_bits;
      logic [31:0] riff_length;
   } wssd_header_type;

endpackage

`default_nettype wire

// ----- hdl/wssd_req_if.sv -----
// Byte input channel of the deframer: valid/ready plus one file byte or an end mark.
// No dependencies.
`default_nettype none

interface wssd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// ----- hdl/wssd_rsp_if.sv -----
// Result channel of the deframer: valid/ready plus status, samples and header values.
// No dependencies.
`default_nettype none

interface wssd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [2:0]  error_kind;
   logic [15:0] left_sample;
   logic [15:0] right_sample;
   logic [31:0] rate_hz;
   logic [31:0] byte_rate;
   logic [15:0] block_align;
   logic [15:0] sample_bits;
   logic [31:0] riff_length;

   modport source (
      output valid, input ready,
      output status, output error_kind, output left_sample, output right_sample,
      output rate_hz, output byte_rate, output block_align, output sample_bits,
      output riff_length
   );
   modport sink (
      input valid, output ready,
      input status, input error_kind, input left_sample, input right_sample,
      input rate_hz, input byte_rate, input block_align, input sample_bits,
      input riff_length
   );
endinterface

`default_nettype wire

// ----- hdl/wssd_front.sv -----
// Parser front end: accepts file bytes, walks the RIFF/WAVE header and data chunks,
// and pushes result entries into the queue. Uses wssd_pkg, wssd_req_if and the macros.
`default_nettype none
`include "wav_stereo_stream_deframer_assert.svh"

module wssd_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   wssd_req_if.sink                      req_chan,
   input  wire logic                     queue_full,
   output logic                          push,
   output wssd_pkg::wssd_entry_type      push_entry,
   output wssd_pkg::wssd_header_type     header
);
   import wssd_pkg::*;

   typedef enum logic [3:0] {
      PH_RIFF_TAG,
      PH_RIFF_LEN,
      PH_WAVE_TAG,
      PH_FMT_TAG,
      PH_FMT_LEN,
      PH_FMT_CODE,
      PH_CHANS,
      PH_RATE,
      PH_BRATE,
      PH_ALIGN,
      PH_BITS,
      PH_CHUNK_TAG,
      PH_CHUNK_LEN,
      PH_DATA,
      PH_DONE,
      PH_ERROR
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [1:0]          count_ff, count_in;
   logic [31:0]         shift_ff, shift_in;
   logic [31:0]         riff_len_ff, riff_len_in;
   logic [31:0]         rate_ff, rate_in;
   logic [31:0]         brate_ff, brate_in;
   logic [15:0]         align_ff, align_in;
   logic [15:0]         bits_ff, bits_in;
   logic [31:0]         chunk_left_ff, chunk_left_in;
   logic [23:0]         pair_ff, pair_in;
   wssd_error_kind_type kind_ff, kind_in;

   logic        accept;
   logic        two_byte;
   logic        last_byte;
   logic [31:0] field_val;
   logic [7:0]  data;

   function automatic wssd_entry_type make_entry(
      input wssd_status_type     st,
      input wssd_error_kind_type kd,
      input logic [15:0]         l,
      input logic [15:0]         r
   );
      wssd_entry_type e;
      e.status = st;
      e.kind   = kd;
      e.left   = l;
      e.right  = r;
      return e;
   endfunction

   // The parser takes a byte whenever the queue has room for its possible result.
   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign data           = req_chan.data_byte;

   // Field assembly: little-endian, two or four bytes depending on the phase.
   assign two_byte  = (phase_ff == PH_FMT_CODE) || (phase_ff == PH_CHANS) ||
                      (phase_ff == PH_ALIGN) || (phase_ff == PH_BITS);
   assign last_byte = (count_ff == 2'd3) || (two_byte && (count_ff == 2'd1));
   assign field_val = shift_ff | ({24'd0, data} << {count_ff, 3'b000});

   // Next-state logic for one accepted item.
   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      shift_in      = shift_ff;
      riff_len_in   = riff_len_ff;
      rate_in       = rate_ff;
      brate_in      = brate_ff;
      align_in      = align_ff;
      bits_in       = bits_ff;
      chunk_left_in = chunk_left_ff;
      pair_in       = pair_ff;
      kind_in       = kind_ff;
      push          = 1'b0;
      push_entry    = make_entry(ST_PAIR, ERR_NONE, 16'd0, 16'd0);

      if (accept) begin
         case (phase_ff)
            PH_ERROR: begin
               push       = 1'b1;
               push_entry = make_entry(ST_ERROR, kind_ff, 16'd0, 16'd0);
            end
            PH_DONE: begin
               push       = 1'b1;
               push_entry = make_entry(ST_DONE, ERR_NONE, 16'd0, 16'd0);
            end
            default: begin
               if (req_chan.end_of_file) begin
                  // End of file is clean only before the first byte of a chunk tag.
                  push = 1'b1;
                  if ((phase_ff == PH_CHUNK_TAG) && (count_ff == 2'd0)) begin
                     phase_in   = PH_DONE;
                     push_entry = make_entry(ST_DONE, ERR_NONE, 16'd0, 16'd0);
                  end else begin
                     phase_in   = PH_ERROR;
                     kind_in    = ERR_TRUNCATED;
                     push_entry = make_entry(ST_ERROR, ERR_TRUNCATED, 16'd0, 16'd0);
                  end
               end else if (phase_ff == PH_DATA) begin
                  // Payload: gather four bytes into a left/right pair.
                  if (count_ff != 2'd3) begin
                     pair_in  = pair_ff | ({16'd0, data} << {count_ff, 3'b000});
                     count_in = count_ff + 2'd1;
                  end else begin
                     push       = 1'b1;
                     push_entry = make_entry(ST_PAIR, ERR_NONE, pair_ff[15:0],
                                             {data, pair_ff[23:16]});
                     count_in   = 2'd0;
                     pair_in    = 24'd0;
                  end
                  chunk_left_in = chunk_left_ff - 32'd1;
                  // The chunk ends after exactly its stated length; a partial pair is dropped.
                  if (chunk_left_ff == 32'd1) begin
                     phase_in = PH_CHUNK_TAG;
                     count_in = 2'd0;
                     shift_in = 32'd0;
                     pair_in  = 24'd0;
                  end
               end else if (!last_byte) begin
                  shift_in = field_val;
                  count_in = count_ff + 2'd1;
               end else begin
                  shift_in = 32'd0;
                  count_in = 2'd0;
                  case (phase_ff)
                     PH_RIFF_TAG: begin
                        if (field_val != TAG_RIFF) begin
                           phase_in   = PH_ERROR;
                           kind_in    = ERR_RIFF;
                           push       = 1'b1;
                           push_entry = make_entry(ST_ERROR, ERR_RIFF, 16'd0, 16'd0);
                        end else begin
                           phase_in = PH_RIFF_LEN;
                        end
                     end
                     PH_RIFF_LEN: begin
                        riff_len_in = field_val;
                        phase_in    = PH_WAVE_TAG;
                     end
                     PH_WAVE_TAG: begin
                        if (field_val != TAG_WAVE) begin
                           phase_in   = PH_ERROR;
                           kind_in    = ERR_WAVE;
                           push       = 1'b1;
                           push_entry = make_entry(ST_ERROR, ERR_WAVE, 16'd0, 16'd0);
                        end else begin
                           phase_in = PH_FMT_TAG;
                        end
                     end
                     PH_FMT_TAG: begin
                        if (field_val != TAG_FMT) begin
                           phase_in   = PH_ERROR;
                           kind_in    = ERR_FMT;
                           push       = 1'b1;
                           push_entry = make_entry(ST_ERROR, ERR_FMT, 16'd0, 16'd0);
                        end else begin
                           phase_in = PH_FMT_LEN;
                        end
                     end
                     PH_FMT_LEN: begin
                        phase_in = PH_FMT_CODE;
                     end
                     PH_FMT_CODE: begin
                        if (field_val != PCM_FORMAT_TAG) begin
                           phase_in   = PH_ERROR;
                           kind_in    = ERR_TAG;
                           push       = 1'b1;
                           push_entry = make_entry(ST_ERROR, ERR_TAG, 16'd0, 16'd0);
                        end else begin
                           phase_in = PH_CHANS;
                        end
                     end
                     PH_CHANS: begin
                        if (field_val != STEREO_CHANNELS) begin
                           phase_in   = PH_ERROR;
                           kind_in    = ERR_CHANNELS;
                           push       = 1'b1;
                           push_entry = make_entry(ST_ERROR, ERR_CHANNELS, 16'd0, 16'd0);
                        end else begin
                           phase_in = PH_RATE;
                        end
                     end
                     PH_RATE: begin
                        rate_in  = field_val;
                        phase_in = PH_BRATE;
                     end
                     PH_BRATE: begin
                        brate_in = field_val;
                        phase_in = PH_ALIGN;
                     end
                     PH_ALIGN: begin
                        align_in = field_val[15:0];
                        phase_in = PH_BITS;
                     end
                     PH_BITS: begin
                        // The format chunk is complete: report it once.
                        bits_in    = field_val[15:0];
                        phase_in   = PH_CHUNK_TAG;
                        push       = 1'b1;
                        push_entry = make_entry(ST_FORMAT, ERR_NONE, 16'd0, 16'd0);
                     end
                     PH_CHUNK_TAG: begin
                        if (field_val != TAG_DATA) begin
                           phase_in   = PH_ERROR;
                           kind_in    = ERR_DATA_TAG;
                           push       = 1'b1;
                           push_entry = make_entry(ST_ERROR, ERR_DATA_TAG, 16'd0, 16'd0);
                        end else begin
                           phase_in = PH_CHUNK_LEN;
                        end
                     end
                     PH_CHUNK_LEN: begin
                        chunk_left_in = field_val;
                        pair_in       = 24'd0;
                        phase_in      = (field_val == 32'd0) ? PH_CHUNK_TAG : PH_DATA;
                     end
                     default: begin
                        phase_in   = PH_ERROR;
                        kind_in    = ERR_TRUNCATED;
                        push       = 1'b1;
                        push_entry = make_entry(ST_ERROR, ERR_TRUNCATED, 16'd0, 16'd0);
                     end
                  endcase
               end
            end
         endcase
      end
   end

   // Parser state and held header values.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_RIFF_TAG;
         count_ff      <= 2'd0;
         shift_ff      <= 32'd0;
         riff_len_ff   <= 32'd0;
         rate_ff       <= 32'd0;
         brate_ff      <= 32'd0;
         align_ff      <= 16'd0;
         bits_ff       <= 16'd0;
         chunk_left_ff <= 32'd0;
         pair_ff       <= 24'd0;
         kind_ff       <= ERR_NONE;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         shift_ff      <= shift_in;
         riff_len_ff   <= riff_len_in;
         rate_ff       <= rate_in;
         brate_ff      <= brate_in;
         align_ff      <= align_in;
         bits_ff       <= bits_in;
         chunk_left_ff <= chunk_left_in;
         pair_ff       <= pair_in;
         kind_ff       <= kind_in;
      end
   end

   assign header.rate_hz     = rate_ff;
   assign header.byte_rate   = brate_ff;
   assign header.block_align = align_ff;
   assign header.sample_bits = bits_ff;
   assign header.riff_length = riff_len_ff;

   // An error or done state is never left until reset.
   `WSSD_ASSERT_NEXT(a_error_sticky, clock, reset, phase_ff == PH_ERROR, phase_ff == PH_ERROR)
   `WSSD_ASSERT_NEXT(a_done_sticky, clock, reset, phase_ff == PH_DONE, phase_ff == PH_DONE)
   // Sample pairs come only from chunk payload, and an error result always names a cause.
   `WSSD_ASSERT_NOW(a_pair_in_data, clock, reset, push && (push_entry.status == ST_PAIR), phase_ff == PH_DATA)
   `WSSD_ASSERT_NOW(a_error_has_kind, clock, reset, push && (push_entry.status == ST_ERROR), push_entry.kind != ERR_NONE)

endmodule

`default_nettype wire

// ----- hdl/wssd_queue.sv -----
// Small first-in first-out queue of result entries between the parser and the output stage.
// Uses wssd_pkg for the entry type.
`default_nettype none

module wssd_queue #(
   parameter int unsigned Depth = wssd_pkg::WSSD_QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wssd_pkg::wssd_entry_type      push_entry,
   output logic                          full,
   input  wire logic                     pop,
   output wssd_pkg::wssd_entry_type      pop_entry,
   output logic                          empty
);
   import wssd_pkg::*;

   localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountW = $clog2(Depth + 1);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
   localparam logic [CountW-1:0] CountFull = CountW'(Depth);

   wssd_entry_type     entries_ff [Depth];
   logic [AddrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;

   // Pointer wrap and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + AddrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + AddrW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CountW'(1);
         2'b01:   count_in = count_ff - CountW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset; only occupied slots are ever read.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry = entries_ff[rd_ptr_ff];
   assign full      = (count_ff == CountFull);
   assign empty     = (count_ff == '0);

endmodule

`default_nettype wire

// ----- hdl/wssd_back.sv -----
// Output stage: pops queued results, joins them with the held header values and
// holds them in the response register. Uses wssd_pkg and wssd_rsp_if.
`default_nettype none

module wssd_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     queue_empty,
   input  wssd_pkg::wssd_entry_type      queue_entry,
   input  wssd_pkg::wssd_header_type     header,
   output logic                          pop,
   wssd_rsp_if.source                    rsp_chan
);
   import wssd_pkg::*;

   logic            valid_ff, valid_in;
   wssd_entry_type  entry_ff;
   wssd_header_type header_ff;

   // Refill the response register whenever it is empty or its transfer completes.
   assign pop      = !queue_empty && (!valid_ff || rsp_chan.ready);
   assign valid_in = pop || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Header values no longer change once any result has been queued.
   always_ff @(posedge clock) begin
      if (pop) begin
         entry_ff  <= queue_entry;
         header_ff <= header;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.status       = entry_ff.status;
   assign rsp_chan.error_kind   = entry_ff.kind;
   assign rsp_chan.left_sample  = entry_ff.left;
   assign rsp_chan.right_sample = entry_ff.right;
   assign rsp_chan.rate_hz      = header_ff.rate_hz;
   assign rsp_chan.byte_rate    = header_ff.byte_rate;
   assign rsp_chan.block_align  = header_ff.block_align;
   assign rsp_chan.sample_bits  = header_ff.sample_bits;
   assign rsp_chan.riff_length  = header_ff.riff_length;

endmodule

`default_nettype wire

// ----- hdl/wav_stereo_stream_deframer.sv -----
// WAV stereo stream deframer top level: parser, result queue and output stage.
// Uses wssd_pkg, wssd_req_if, wssd_rsp_if, wssd_front, wssd_queue and wssd_back.
//
// Usage:
// The req_chan channel carries one file byte per transfer, or an end-of-file mark
// (end_of_file high, data_byte ignored). The rsp_chan channel carries at most one
// result per input transfer: a left/right sample pair, a single format-accepted
// report after the fmt chunk, done at a clean end of file, or an error with its kind.
// Every result also carries the held header values.
// Throughput is one byte per clock; the parser takes a byte in every cycle in which
// the result queue has room. A result passes through the queue and the response register
// before it appears on rsp_chan. When the receiver stalls, results collect in the
// queue (QueueDepth entries) and the response register, and req_chan ready drops
// once the queue is full; no result is lost.
// Synchronous reset returns the parser to expecting the RIFF tag, clears the held
// header values and any latched error, and empties the queue; there is no clearing pass.
// After done or an error, every further input transfer answers the same status again.
`default_nettype none

module wav_stereo_stream_deframer #(
   parameter int unsigned QueueDepth = wssd_pkg::WSSD_QUEUE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   wssd_req_if.sink    req_chan,
   wssd_rsp_if.source  rsp_chan
);
   import wssd_pkg::*;

   logic            push;
   logic            pop;
   logic            queue_full;
   logic            queue_empty;
   wssd_entry_type  push_entry;
   wssd_entry_type  pop_entry;
   wssd_header_type header;

   // Front end: byte parsing and classification.
   wssd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry),
      .header     (header)
   );

   // Decoupling queue.
   wssd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   // Back end: response register.
   wssd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_entry (pop_entry),
      .header      (header),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for wav_stereo_stream_deframer: one generated WAV byte stream
// goes in through wssd_req_if and every result on wssd_rsp_if is checked against a model.
// Depends on wssd_pkg, wssd_req_if, wssd_rsp_if and the deframer top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wssd_pkg::*;

   // Parser phases, in the order the file presents its fields.
   typedef enum logic [3:0] {
      P_RIFF_TAG, P_RIFF_LEN, P_WAVE_TAG, P_FMT_TAG, P_FMT_LEN, P_FMT_CODE,
      P_CHANS, P_RATE, P_BRATE, P_ALIGN, P_BITS, P_CHUNK_TAG, P_CHUNK_LEN,
      P_DATA, P_DONE, P_ERROR
   } parse_phase_type;

   // A full result: the queued part plus the header values shown with it.
   typedef struct packed {
      wssd_entry_type  entry;
      wssd_header_type header;
   } wav_result_type;

   // Shadow copy of the parser; it predicts results and matches the ones that arrive.
   class deframer_shadow;
      parse_phase_type     phase;
      int unsigned         field_count;
      logic [31:0]         field_bits;
      logic [31:0]         chunk_length;
      logic [31:0]         chunk_seen;
      logic [23:0]         pair_bits;
      wssd_error_kind_type held_kind;
      wssd_header_type     header;
      wav_result_type      awaited[$];
      int unsigned         mismatches;

      function new();
         phase = P_RIFF_TAG;
         field_count = 0;
         field_bits = '0;
         chunk_length = '0;
         chunk_seen = '0;
         pair_bits = '0;
         held_kind = ERR_NONE;
         header = '0;
         mismatches = 0;
      endfunction

      function void post(wssd_status_type status, wssd_error_kind_type kind,
                         logic [15:0] left, logic [15:0] right);
         wav_result_type r;
         r.entry.status = status;
         r.entry.kind = kind;
         r.entry.left = left;
         r.entry.right = right;
         r.header = header;
         awaited.push_back(r);
      endfunction

      function void latch_error(wssd_error_kind_type kind);
         held_kind = kind;
         phase = P_ERROR;
         post(ST_ERROR, kind, 16'h0, 16'h0);
      endfunction

      // Advance the model by one accepted input transfer.
      function void take_item(logic [7:0] data_byte, logic end_of_file);
         logic [31:0] word;
         int unsigned width;
         if (phase == P_ERROR) begin
            post(ST_ERROR, held_kind, 16'h0, 16'h0);
            return;
         end
         if (phase == P_DONE) begin
            post(ST_DONE, ERR_NONE, 16'h0, 16'h0);
            return;
         end

         // End of file is clean only right before a chunk tag.
         if (end_of_file) begin
            if (phase == P_CHUNK_TAG && field_count == 0) begin
               phase = P_DONE;
               post(ST_DONE, ERR_NONE, 16'h0, 16'h0);
            end else begin
               latch_error(ERR_TRUNCATED);
            end
            return;
         end

         // Payload: four bytes make a pair; a trailing partial pair is dropped.
         if (phase == P_DATA) begin
            if (field_count < 3) begin
               pair_bits[8*field_count +: 8] = data_byte;
               field_count++;
            end else begin
               post(ST_PAIR, ERR_NONE, pair_bits[15:0], {data_byte, pair_bits[23:16]});
               field_count = 0;
               pair_bits = '0;
            end
            chunk_seen = chunk_seen + 32'd1;
            if (chunk_seen == chunk_length) begin
               phase = P_CHUNK_TAG;
               field_count = 0;
               field_bits = '0;
               pair_bits = '0;
            end
            return;
         end

         // Header fields collect little-endian and are judged on their last byte.
         field_bits[8*field_count +: 8] = data_byte;
         field_count++;
         width = (phase inside {P_FMT_CODE, P_CHANS, P_ALIGN, P_BITS}) ? 2 : 4;
         if (field_count < width) return;
         word = field_bits;
         field_bits = '0;
         field_count = 0;

         case (phase)
            P_RIFF_TAG: begin
               if (word != TAG_RIFF) latch_error(ERR_RIFF);
               else phase = P_RIFF_LEN;
            end
            P_RIFF_LEN: begin
               header.riff_length = word;
               phase = P_WAVE_TAG;
            end
            P_WAVE_TAG: begin
               if (word != TAG_WAVE) latch_error(ERR_WAVE);
               else phase = P_FMT_TAG;
            end
            P_FMT_TAG: begin
               if (word != TAG_FMT) latch_error(ERR_FMT);
               else phase = P_FMT_LEN;
            end
            P_FMT_LEN: phase = P_FMT_CODE;
            P_FMT_CODE: begin
               if (word != PCM_FORMAT_TAG) latch_error(ERR_TAG);
               else phase = P_CHANS;
            end
            P_CHANS: begin
               if (word != STEREO_CHANNELS) latch_error(ERR_CHANNELS);
               else phase = P_RATE;
            end
            P_RATE: begin
               header.rate_hz = word;
               phase = P_BRATE;
            end
            P_BRATE: begin
               header.byte_rate = word;
               phase = P_ALIGN;
            end
            P_ALIGN: begin
               header.block_align = word[15:0];
               phase = P_BITS;
            end
            P_BITS: begin
               header.sample_bits = word[15:0];
               phase = P_CHUNK_TAG;
               post(ST_FORMAT, ERR_NONE, 16'h0, 16'h0);
            end
            P_CHUNK_TAG: begin
               if (word != TAG_DATA) latch_error(ERR_DATA_TAG);
               else phase = P_CHUNK_LEN;
            end
            P_CHUNK_LEN: begin
               chunk_length = word;
               chunk_seen = '0;
               pair_bits = '0;
               phase = (word == 32'h0) ? P_CHUNK_TAG : P_DATA;
            end
            default: latch_error(ERR_TRUNCATED);
         endcase
      endfunction

      function void check_field(string name, logic [31:0] expected, logic [31:0] actual);
         if (expected !== actual) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            mismatches++;
         end
      endfunction

      // Compare one received result with the oldest prediction.
      function void match_result(wav_result_type got);
         wav_result_type want;
         if (awaited.size() == 0) begin
            $error("result transfer with nothing outstanding (status %0d)", got.entry.status);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         check_field("status", 32'(want.entry.status), 32'(got.entry.status));
         check_field("error_kind", 32'(want.entry.kind), 32'(got.entry.kind));
         check_field("left_sample", 32'(want.entry.left), 32'(got.entry.left));
         check_field("right_sample", 32'(want.entry.right), 32'(got.entry.right));
         check_field("rate_hz", want.header.rate_hz, got.header.rate_hz);
         check_field("byte_rate", want.header.byte_rate, got.header.byte_rate);
         check_field("block_align", 32'(want.header.block_align),
                     32'(got.header.block_align));
         check_field("sample_bits", 32'(want.header.sample_bits),
                     32'(got.header.sample_bits));
         check_field("riff_length", want.header.riff_length, got.header.riff_length);
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;

   wssd_req_if req_chan();
   wssd_rsp_if rsp_chan();

   wav_stereo_stream_deframer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deframer_shadow shadow;

   // The file as a list of transfers: bit 8 marks end of file, bits 7:0 the byte.
   logic [8:0] file_items[$];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void put_byte(logic [7:0] b);
      file_items.push_back({1'b0, b});
   endfunction

   // The byte that travels with an end mark is ignored, so it is random.
   function automatic void put_end();
      file_items.push_back({1'b1, 8'($urandom)});
   endfunction

   function automatic void put_word(logic [31:0] w, int unsigned n);
      for (int unsigned i = 0; i < n; i++) put_byte(w[8*i +: 8]);
   endfunction

   function automatic void put_chunk_head(logic [31:0] length);
      put_word(TAG_DATA, 4);
      put_word(length, 4);
   endfunction

   // Header values lean toward the extremes.
   function automatic logic [31:0] header_word();
      case ($urandom_range(0, 3))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic void build_file();
      int unsigned length;
      // A well-formed header with random content.
      put_word(TAG_RIFF, 4);
      put_word(header_word(), 4);
      put_word(TAG_WAVE, 4);
      put_word(TAG_FMT, 4);
      put_word($urandom, 4);
      put_word(PCM_FORMAT_TAG, 2);
      put_word(STEREO_CHANNELS, 2);
      put_word(header_word(), 4);
      put_word(header_word(), 4);
      put_word(header_word(), 2);
      put_word(header_word(), 2);

      // Directed chunks: empty, a lone dropped byte, extreme samples, partial tails.
      put_chunk_head(32'd0);
      put_chunk_head(32'd1);
      put_byte(8'hFF);
      put_chunk_head(32'd8);
      put_word(32'h0000_FFFF, 4);
      put_word(32'hFFFF_0000, 4);
      put_chunk_head(32'd7);
      put_word(32'h8001_7FFE, 4);
      put_word(32'h00FF_00FF, 3);
      put_chunk_head(32'd2);
      put_word(32'h0000_00FF, 2);
      put_chunk_head(32'd3);
      put_word(32'h00FF_FF00, 3);

      // Random chunks, mostly short, now and then long.
      while (file_items.size() < 2000) begin
         length = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 300) : $urandom_range(0, 64);
         put_chunk_head(length);
         repeat (length) put_byte($urandom);
      end

      // One way to end the file: clean, cut short in some field, or a bad chunk tag.
      case ($urandom_range(0, 4))
         0: put_end();
         1: begin
            put_chunk_head(($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom_range(8, 100));
            repeat ($urandom_range(0, 7)) put_byte($urandom);
            put_end();
         end
         2: begin
            put_word(TAG_DATA, $urandom_range(1, 3));
            put_end();
         end
         3: put_word(TAG_DATA ^ (32'h1 << $urandom_range(0, 31)), 4);
         default: begin
            put_word(TAG_DATA, 4);
            put_word($urandom, $urandom_range(0, 3));
            put_end();
         end
      endcase

      // Once finished or failed, every further transfer repeats the final status.
      repeat (24) begin
         if ($urandom_range(0, 1) == 0) put_end();
         else put_byte($urandom);
      end
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic offer_item(logic [8:0] item);
      req_chan.valid <= 1'b1;
      req_chan.end_of_file <= item[8];
      req_chan.data_byte <= item[7:0];
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      shadow.take_item(item[7:0], item[8]);
   endtask

   task automatic pause_sender(int unsigned cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender: reset, then the whole file, with idle bursts except near the end.
   initial begin
      int unsigned idx;
      shadow = new();
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data_byte <= 8'h0;
      req_chan.end_of_file <= 1'b0;
      build_file();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (idx = 0; idx < file_items.size(); idx++) begin
         calm = (idx >= file_items.size() - file_items.size() / 8);
         if (!calm && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 11));
         offer_item(file_items[idx]);
      end
      req_chan.valid <= 1'b0;
      while (shadow.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
         $display("** wav_stereo_stream_deframer: PASSED **");
      end else begin
         $display("** wav_stereo_stream_deframer: FAILED **");
      end
      $finish;
   end

   // Receiver: random stall bursts, plus one long hold-off so the queue fills up.
   initial begin
      int unsigned stall_left;
      int unsigned taken;
      bit held_off;
      bit open;
      wav_result_type got;
      stall_left = 0;
      taken = 0;
      held_off = 1'b0;
      forever begin
         if (!held_off && taken == 40) begin
            held_off = 1'b1;
            stall_left = 400;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11);
         end
         open = (stall_left == 0);
         if (!open) stall_left--;
         rsp_chan.ready <= open;
         @(posedge clock);
         if (open && rsp_chan.valid === 1'b1 && reset === 1'b0) begin
            got.entry.status = wssd_status_type'(rsp_chan.status);
            got.entry.kind = wssd_error_kind_type'(rsp_chan.error_kind);
            got.entry.left = rsp_chan.left_sample;
            got.entry.right = rsp_chan.right_sample;
            got.header.rate_hz = rsp_chan.rate_hz;
            got.header.byte_rate = rsp_chan.byte_rate;
            got.header.block_align = rsp_chan.block_align;
            got.header.sample_bits = rsp_chan.sample_bits;
            got.header.riff_length = rsp_chan.riff_length;
            shadow.match_result(got);
            taken++;
         end
      end
   end

   // Hard stop in case the handshakes hang.
   initial begin
      #5_000_000;
      $display("** wav_stereo_stream_deframer: FAILED **");
      $finish;
   end

endmodule
